[sv/szsrt_pkg.sv]
// ----------------------------------------------------------------------------
// szsrt_pkg: shared types and helpers of the short zero-sum reach tracker
// Types for torus coordinates and reach levels, element decoding and
// coordinate arithmetic modulo five.
// ----------------------------------------------------------------------------
package szsrt_pkg;

  localparam int AXIS_LEN        = 5;
  localparam int PLANE_BITS      = AXIS_LEN * AXIS_LEN;
  localparam int GROUP_SIZE      = AXIS_LEN * PLANE_BITS;
  localparam int MAX_SUM_LEN_DEF = 5;
  localparam int MAX_COPIES      = 4;

  typedef logic [2:0] coord_t;
  typedef logic [PLANE_BITS-1:0] plane_t;
  typedef plane_t [AXIS_LEN-1:0] level_t;

  typedef struct packed {
    coord_t dx;
    coord_t dy;
    coord_t dz;
  } delta_t;

  localparam level_t LEVEL_ORIGIN = level_t'(1);

  // (a - b) mod 5 for coordinates in 0..4.
  function automatic coord_t sub5(input coord_t a, input coord_t b);
    coord_t res;
    if (a >= b) begin
      res = coord_t'(a - b);
    end else begin
      res = coord_t'(a + coord_t'(AXIS_LEN) - b);
    end
    return res;
  endfunction

  // Splits an element code x*25 + y*5 + z into its coordinates. Codes 125
  // and above wrap their x coordinate back to zero.
  function automatic delta_t decode_elem(input logic [6:0] code);
    delta_t     d;
    logic [6:0] r;
    logic [6:0] q;
    if (code >= 7'(GROUP_SIZE)) begin
      d.dx = 3'd0; r = code - 7'(GROUP_SIZE);
    end else if (code >= 7'(4 * PLANE_BITS)) begin
      d.dx = 3'd4; r = code - 7'(4 * PLANE_BITS);
    end else if (code >= 7'(3 * PLANE_BITS)) begin
      d.dx = 3'd3; r = code - 7'(3 * PLANE_BITS);
    end else if (code >= 7'(2 * PLANE_BITS)) begin
      d.dx = 3'd2; r = code - 7'(2 * PLANE_BITS);
    end else if (code >= 7'(PLANE_BITS)) begin
      d.dx = 3'd1; r = code - 7'(PLANE_BITS);
    end else begin
      d.dx = 3'd0; r = code;
    end
    if (r >= 7'(4 * AXIS_LEN)) begin
      d.dy = 3'd4; q = r - 7'(4 * AXIS_LEN);
    end else if (r >= 7'(3 * AXIS_LEN)) begin
      d.dy = 3'd3; q = r - 7'(3 * AXIS_LEN);
    end else if (r >= 7'(2 * AXIS_LEN)) begin
      d.dy = 3'd2; q = r - 7'(2 * AXIS_LEN);
    end else if (r >= 7'(AXIS_LEN)) begin
      d.dy = 3'd1; q = r - 7'(AXIS_LEN);
    end else begin
      d.dy = 3'd0; q = r;
    end
    d.dz = q[2:0];
    return d;
  endfunction

endpackage

[sv/szsrt_shift.sv]
// ----------------------------------------------------------------------------
// szsrt_shift: torus translation of one reach level
// Moves all 125 points of a level by a group element on the 5x5x5 torus and
// flags whether the translated set covers the origin.
// ----------------------------------------------------------------------------
module szsrt_shift (
  input  szsrt_pkg::level_t src,
  input  szsrt_pkg::delta_t dlt,
  output szsrt_pkg::level_t moved,
  output logic              origin_hit
);

  always_comb begin
    szsrt_pkg::coord_t sx;
    szsrt_pkg::coord_t sy;
    szsrt_pkg::coord_t sz;
    logic [4:0]        bi;
    moved = '0;
    for (int x = 0; x < szsrt_pkg::AXIS_LEN; x++) begin
      for (int y = 0; y < szsrt_pkg::AXIS_LEN; y++) begin
        for (int z = 0; z < szsrt_pkg::AXIS_LEN; z++) begin
          // Each target point pulls from the point one element behind it.
          sx = szsrt_pkg::sub5(3'(x), dlt.dx);
          sy = szsrt_pkg::sub5(3'(y), dlt.dy);
          sz = szsrt_pkg::sub5(3'(z), dlt.dz);
          bi = 5'(sy * szsrt_pkg::AXIS_LEN + sz);
          moved[x][y * szsrt_pkg::AXIS_LEN + z] = src[sx][bi];
        end
      end
    end
  end

  assign origin_hit = moved[0][0];

endmodule

[sv/short_zero_sum_reach_tracker_core.sv]
// ----------------------------------------------------------------------------
// short_zero_sum_reach_tracker_core: zero-sum reach tracker over Z5^3
// Keeps the reachable sums of each length 0..MAX_SUM_LEN and rejects any add
// request that would create a zero-sum of length at most MAX_SUM_LEN.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  in_     | input     | in_valid/in_stall  | in_action, in_element, in_copies
//  out_    | output    | out_valid/out_stall| out_accepted
//
//  An accepted add walks levels MAX_SUM_LEN down to 1 once per copy (copies
//  saturate at 4), one level per cycle through one shared torus shift unit;
//  a rejected add stops at the level whose shift hits the origin; a clear or
//  zero-copy add skips the pass. Reset restores the origin-only level 0, all
//  else empty. in_stall is high while a request is in flight; a stalled
//  result holds the block in its final state until the output register frees.
// ----------------------------------------------------------------------------
module short_zero_sum_reach_tracker_core #(
  parameter int MAX_SUM_LEN = szsrt_pkg::MAX_SUM_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_action,
  input  logic [6:0] in_element,
  input  logic [2:0] in_copies,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_accepted
);

  localparam int LEVELS = MAX_SUM_LEN + 1;
  localparam int LVL_W  = $clog2(LEVELS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  szsrt_pkg::level_t state_r [LEVELS];
  szsrt_pkg::level_t work_r  [LEVELS];

  logic [1:0]        fsm_r, fsm_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [2:0]        copies_r, copies_nxt;
  logic              res_r, res_nxt;
  logic              add_r, add_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_acc_r, out_acc_nxt;
  szsrt_pkg::delta_t dlt_r;

  logic              in_fire;
  logic              out_free;
  logic              commit;
  logic [LVL_W-1:0]  lvl_prev;
  logic [2:0]        copies_sat;
  szsrt_pkg::level_t moved;
  logic              origin_hit;

  assign in_stall  = (fsm_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign commit    = (fsm_r == S_FIN) && out_free && res_r && add_r;
  assign lvl_prev  = lvl_r - LVL_W'(1);
  assign copies_sat = (in_copies > 3'(szsrt_pkg::MAX_COPIES)) ?
                      3'(szsrt_pkg::MAX_COPIES) : in_copies;

  szsrt_shift u_shift (
    .src        (work_r[lvl_prev]),
    .dlt        (dlt_r),
    .moved      (moved),
    .origin_hit (origin_hit)
  );

  always_comb begin
    fsm_nxt       = fsm_r;
    lvl_nxt       = lvl_r;
    copies_nxt    = copies_r;
    res_nxt       = res_r;
    add_nxt       = add_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_acc_nxt   = out_acc_r;
    unique case (fsm_r)
      S_IDLE: begin
        if (in_fire) begin
          add_nxt    = in_action;
          res_nxt    = 1'b1;
          copies_nxt = copies_sat;
          lvl_nxt    = LVL_W'(MAX_SUM_LEN);
          if (in_action && (copies_sat != 3'd0)) begin
            fsm_nxt = S_RUN;
          end else begin
            fsm_nxt = S_FIN;
          end
        end
      end
      S_RUN: begin
        if (origin_hit) begin
          res_nxt = 1'b0;
          fsm_nxt = S_FIN;
        end else if (lvl_r == LVL_W'(1)) begin
          if (copies_r == 3'd1) begin
            fsm_nxt = S_FIN;
          end else begin
            copies_nxt = copies_r - 3'd1;
            lvl_nxt    = LVL_W'(MAX_SUM_LEN);
          end
        end else begin
          lvl_nxt = lvl_prev;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = res_r;
          fsm_nxt       = S_IDLE;
        end
      end
      default: begin
        fsm_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= S_IDLE;
      lvl_r       <= '0;
      copies_r    <= '0;
      res_r       <= 1'b0;
      add_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_acc_r   <= 1'b0;
    end else begin
      fsm_r       <= fsm_nxt;
      lvl_r       <= lvl_nxt;
      copies_r    <= copies_nxt;
      res_r       <= res_nxt;
      add_r       <= add_nxt;
      out_valid_r <= out_valid_nxt;
      out_acc_r   <= out_acc_nxt;
    end
  end

  // Committed sets: cleared by reset or a clear request, replaced by the
  // working copy once an add request has passed every check.
  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && !in_action)) begin
      for (int i = 0; i < LEVELS; i++) begin
        state_r[i] <= (i == 0) ? szsrt_pkg::LEVEL_ORIGIN : '0;
      end
    end else if (commit) begin
      state_r <= work_r;
    end
  end

  // Working copy. Levels are updated in descending order, so the level read
  // by the shift unit still holds its value from before the current pass.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      work_r <= state_r;
      dlt_r  <= szsrt_pkg::decode_elem(in_element);
    end else if (fsm_r == S_RUN) begin
      work_r[lvl_r] <= work_r[lvl_r] | moved;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_accepted = out_acc_r;

  a_level0_origin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r[0] == szsrt_pkg::LEVEL_ORIGIN)
    else $error("level 0 of the committed sets lost its origin-only value");

  a_run_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == S_RUN) |-> (lvl_r != '0) && (lvl_r <= LVL_W'(MAX_SUM_LEN)))
    else $error("level counter out of range during a pass");

  a_hit_rejects: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == S_RUN) && origin_hit |=> (fsm_r == S_FIN) && !res_r)
    else $error("origin hit did not lead to a rejection");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(fsm_r) == S_FIN))
    else $error("result appeared outside the final state");

endmodule
